[hw/rtl/av1_sequence_header_parser_macros.svh]
// assertion macros for the av1 sequence header parser
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef AV1_SEQUENCE_HEADER_PARSER_MACROS_SVH
`define AV1_SEQUENCE_HEADER_PARSER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define AV1SH_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("av1sh assertion failed");
`define AV1SH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("av1sh assertion failed");
`else
`define AV1SH_ASSERT_SAME(lbl, ante, cons)
`define AV1SH_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[hw/rtl/av1sh_pkg.sv]
// shared types, element codes and helpers for the av1 sequence header parser
// no dependencies
package av1sh_pkg;

    localparam int MAX_POINTS = 32;
    localparam int PT_W = $clog2(MAX_POINTS);
    localparam int MAX_RES = 6;
    localparam int CNT_W = $clog2(MAX_RES + 1);

    typedef enum logic [5:0] {
        E_PROFILE, E_STILL, E_REDUCED, E_TIMING, E_DISP_TICK, E_TIME_SCALE,
        E_EQUAL, E_TICKS_M1, E_DMI, E_BDL, E_DEC_TICK, E_BRTL, E_FPTL, E_IDD,
        E_OPS, E_IDC, E_LEVEL, E_TIER, E_MODEL_OP, E_DEC_DELAY, E_ENC_DELAY,
        E_LOW_DELAY, E_IDD_OP, E_IDD_M1, E_SEL_LEVEL, E_SEL_TIER, E_FWB, E_FHB,
        E_MAXW, E_MAXH, E_FID, E_DELTA_ID, E_ADD_ID, E_SB128, E_FINTRA, E_EDGE,
        E_INTERINTRA, E_MASKED, E_WARPED, E_DUAL, E_ORDER, E_JNT, E_REFMVS,
        E_SCT, E_IMV, E_OHB, E_SUPERRES, E_CDEF, E_RESTORE, E_BIT_DEPTH,
        E_MONO, E_PRIM, E_TRANSFER, E_MATRIX, E_RANGE, E_SSX, E_SSY, E_CSP,
        E_SEP_UV, E_FILM
    } elem_t;

    typedef enum logic [1:0] {
        ST_ELEM, ST_DONE, ST_BAD_DATA, ST_BAD_ARG
    } status_t;

    typedef struct packed {
        logic header_bit;
        logic starts_header;
    } in_t;

    typedef struct packed {
        logic [5:0]      element_code;
        logic [31:0]     element_value;
        logic [PT_W-1:0] point_index;
        logic [1:0]      parse_status;
        logic            run_last;
    } out_t;

    typedef struct packed {
        logic [5:0]      code;
        logic [31:0]     value;
        logic [PT_W-1:0] point;
        status_t         status;
    } res_t;

    typedef struct packed {
        res_t [MAX_RES-1:0] slot;
        logic [CNT_W-1:0]   cnt;
    } batch_t;

    function automatic batch_t push(batch_t b, logic [5:0] code, logic [31:0] value,
                                    logic [PT_W-1:0] point, status_t st);
        batch_t r;
        r = b;
        if (b.cnt < CNT_W'(MAX_RES))
        begin
            r.slot[b.cnt] = '{code, value, point, st};
            r.cnt = b.cnt + CNT_W'(1);
        end
        return r;
    endfunction

endpackage

[hw/rtl/av1sh_step.sv]
// per-bit syntax step: parse state registers and the result batch of one bit
// depends on av1sh_pkg
module av1sh_step (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  av1sh_pkg::in_t                word,
    input  logic                          cfg_we,
    input  logic [av1sh_pkg::PT_W-1:0]    cfg_data,
    output av1sh_pkg::batch_t             batch
);

    typedef enum logic [6:0] {
        S_IDLE, S_PROFILE, S_STILL, S_REDUCED, S_RLEVEL, S_TIMING, S_DISP_TICK,
        S_TIME_SCALE, S_EQUAL, S_UVLC, S_UVLC_BITS, S_DMI, S_BDL, S_DEC_TICK,
        S_BRTL, S_FPTL, S_IDD, S_OPS, S_IDC, S_LEVEL, S_TIER, S_MODEL_OP,
        S_DEC_DELAY, S_ENC_DELAY, S_LOW_DELAY, S_IDD_OP, S_IDD_M1, S_FWB, S_FHB,
        S_MAXW, S_MAXH, S_FID, S_DELTA_ID, S_ADD_ID, S_SB128, S_FINTRA, S_EDGE,
        S_INTERINTRA, S_MASKED, S_WARPED, S_DUAL, S_ORDER, S_JNT, S_REFMVS,
        S_SCT_CHOOSE, S_SCT, S_IMV_CHOOSE, S_IMV, S_OHB, S_SUPERRES, S_CDEF,
        S_RESTORE, S_HIGH_BD, S_TWELVE, S_MONO, S_DESC, S_PRIM, S_TRANSFER,
        S_MATRIX, S_RANGE, S_SSX, S_SSY, S_CSP, S_SEP_UV, S_FILM, S_TRAIL_ONE,
        S_TRAIL_ZERO
    } step_t;

    typedef struct packed {
        step_t       step;
        logic [5:0]  left;
        logic [31:0] acc;
        logic [5:0]  zc;
        logic [2:0]  prof;
        logic        still;
        logic        reduced;
        logic        dmi;
        logic        idd;
        logic        order;
        logic        mono;
        logic        tick0;
        logic [5:0]  dlen;
        logic [av1sh_pkg::PT_W-1:0] pm1;
        logic [av1sh_pkg::PT_W-1:0] pc;
        logic [4:0]  wbits;
        logic [4:0]  hbits;
        logic [23:0] colour;
        logic [1:0]  depth;
        logic [2:0]  pos;
        logic [4:0]  lvl;
        logic        tier;
    } st_t;

    typedef struct packed {
        logic       en;
        step_t      step;
        logic [5:0] len;
    } go_t;

    st_t st_reg, st_next, cur;
    logic [av1sh_pkg::PT_W-1:0] sel_reg, sel_next;
    av1sh_pkg::batch_t b;
    go_t g;
    logic [31:0] v;
    logic [5:0] left1;
    logic bit_in, vb, do_at, do_am, do_pd, do_ai, do_ad, do_desc;

    function automatic go_t gt(step_t s, logic [5:0] l);
        go_t r;
        r.en = 1'b1;
        r.step = s;
        r.len = l;
        return r;
    endfunction

    function automatic av1sh_pkg::batch_t em(av1sh_pkg::batch_t bi, av1sh_pkg::elem_t c,
                                             logic [31:0] val);
        return av1sh_pkg::push(bi, c, val, '0, av1sh_pkg::ST_ELEM);
    endfunction

    function automatic av1sh_pkg::batch_t emp(av1sh_pkg::batch_t bi, av1sh_pkg::elem_t c,
                                              logic [31:0] val,
                                              logic [av1sh_pkg::PT_W-1:0] p);
        return av1sh_pkg::push(bi, c, val, p, av1sh_pkg::ST_ELEM);
    endfunction

    function automatic av1sh_pkg::batch_t fin(av1sh_pkg::batch_t bi, av1sh_pkg::status_t s);
        return av1sh_pkg::push(bi, '0, '0, '0, s);
    endfunction

    always_comb
    begin
        bit_in = word.header_bit;
        cur = st_reg;
        if (word.starts_header)
        begin
            cur = '0;
            cur.step = S_PROFILE;
            cur.left = 6'd3;
        end
        st_next = cur;
        b = '0;
        g = '0;
        v = {cur.acc[30:0], bit_in};
        vb = (v != '0);
        left1 = (cur.left != '0) ? cur.left - 6'd1 : '0;
        do_at = 1'b0;
        do_am = 1'b0;
        do_pd = 1'b0;
        do_ai = 1'b0;
        do_ad = 1'b0;
        do_desc = 1'b0;
        sel_next = cfg_we ? cfg_data : sel_reg;
        if (cur.step != S_IDLE)
        begin
            st_next.pos = cur.pos + 3'd1;
            if (cur.step == S_UVLC)
            begin
                if (!bit_in)
                begin
                    if (cur.zc < 6'd32)
                        st_next.zc = cur.zc + 6'd1;
                end
                else if (cur.zc >= 6'd32)
                begin
                    b = em(b, av1sh_pkg::E_TICKS_M1, 32'hFFFF_FFFF);
                    g = gt(S_DMI, 6'd1);
                end
                else if (cur.zc == '0)
                begin
                    b = em(b, av1sh_pkg::E_TICKS_M1, '0);
                    g = gt(S_DMI, 6'd1);
                end
                else
                    g = gt(S_UVLC_BITS, cur.zc);
            end
            else if (cur.step == S_TRAIL_ONE || cur.step == S_TRAIL_ZERO)
            begin
                if (bit_in != (cur.step == S_TRAIL_ONE))
                begin
                    b = fin(b, av1sh_pkg::ST_BAD_DATA);
                    g = gt(S_IDLE, '0);
                end
                else if (st_next.pos == '0)
                begin
                    b = fin(b, av1sh_pkg::ST_DONE);
                    g = gt(S_IDLE, '0);
                end
                else
                    g = gt(S_TRAIL_ZERO, '0);
            end
            else
            begin
                st_next.acc = v;
                st_next.left = left1;
                if (left1 == '0)
                begin
                    unique case (cur.step)
                        S_PROFILE:
                        begin
                            st_next.prof = v[2:0];
                            b = em(b, av1sh_pkg::E_PROFILE, v);
                            g = gt(S_STILL, 6'd1);
                        end
                        S_STILL:
                        begin
                            st_next.still = vb;
                            b = em(b, av1sh_pkg::E_STILL, v);
                            g = gt(S_REDUCED, 6'd1);
                        end
                        S_REDUCED:
                        begin
                            st_next.reduced = vb;
                            b = em(b, av1sh_pkg::E_REDUCED, v);
                            if (cur.prof > 3'd2 || (vb && !cur.still))
                            begin
                                b = fin(b, av1sh_pkg::ST_BAD_DATA);
                                g = gt(S_IDLE, '0);
                            end
                            else if (vb)
                            begin
                                if (sel_reg != '0)
                                begin
                                    b = fin(b, av1sh_pkg::ST_BAD_ARG);
                                    g = gt(S_IDLE, '0);
                                end
                                else
                                    g = gt(S_RLEVEL, 6'd5);
                            end
                            else
                                g = gt(S_TIMING, 6'd1);
                        end
                        S_RLEVEL:
                        begin
                            st_next.pc = '0;
                            b = emp(b, av1sh_pkg::E_LEVEL, v, '0);
                            b = em(b, av1sh_pkg::E_OPS, 32'd1);
                            b = emp(b, av1sh_pkg::E_SEL_LEVEL, v, '0);
                            b = emp(b, av1sh_pkg::E_SEL_TIER, '0, '0);
                            g = gt(S_FWB, 6'd4);
                        end
                        S_TIMING:
                        begin
                            b = em(b, av1sh_pkg::E_TIMING, v);
                            g = vb ? gt(S_DISP_TICK, 6'd32) : gt(S_IDD, 6'd1);
                        end
                        S_DISP_TICK:
                        begin
                            st_next.tick0 = !vb;
                            b = em(b, av1sh_pkg::E_DISP_TICK, v);
                            g = gt(S_TIME_SCALE, 6'd32);
                        end
                        S_TIME_SCALE:
                        begin
                            b = em(b, av1sh_pkg::E_TIME_SCALE, v);
                            if (cur.tick0 || !vb)
                            begin
                                b = fin(b, av1sh_pkg::ST_BAD_DATA);
                                g = gt(S_IDLE, '0);
                            end
                            else
                                g = gt(S_EQUAL, 6'd1);
                        end
                        S_EQUAL:
                        begin
                            b = em(b, av1sh_pkg::E_EQUAL, v);
                            if (vb)
                            begin
                                g = gt(S_UVLC, '0);
                                st_next.zc = '0;
                            end
                            else
                                g = gt(S_DMI, 6'd1);
                        end
                        S_UVLC_BITS:
                        begin
                            b = em(b, av1sh_pkg::E_TICKS_M1,
                                   v + ((32'd1 << cur.zc[4:0]) - 32'd1));
                            g = gt(S_DMI, 6'd1);
                        end
                        S_DMI:
                        begin
                            st_next.dmi = vb;
                            b = em(b, av1sh_pkg::E_DMI, v);
                            g = vb ? gt(S_BDL, 6'd5) : gt(S_IDD, 6'd1);
                        end
                        S_BDL:
                        begin
                            st_next.dlen = {1'b0, v[4:0]} + 6'd1;
                            b = em(b, av1sh_pkg::E_BDL, 32'(st_next.dlen));
                            g = gt(S_DEC_TICK, 6'd32);
                        end
                        S_DEC_TICK:
                        begin
                            b = em(b, av1sh_pkg::E_DEC_TICK, v);
                            if (!vb)
                            begin
                                b = fin(b, av1sh_pkg::ST_BAD_DATA);
                                g = gt(S_IDLE, '0);
                            end
                            else
                                g = gt(S_BRTL, 6'd5);
                        end
                        S_BRTL:
                        begin
                            b = em(b, av1sh_pkg::E_BRTL, v + 32'd1);
                            g = gt(S_FPTL, 6'd5);
                        end
                        S_FPTL:
                        begin
                            b = em(b, av1sh_pkg::E_FPTL, v + 32'd1);
                            g = gt(S_IDD, 6'd1);
                        end
                        S_IDD:
                        begin
                            st_next.idd = vb;
                            b = em(b, av1sh_pkg::E_IDD, v);
                            g = gt(S_OPS, 6'd5);
                        end
                        S_OPS:
                        begin
                            st_next.pm1 = v[av1sh_pkg::PT_W-1:0];
                            st_next.pc = '0;
                            b = em(b, av1sh_pkg::E_OPS, v + 32'd1);
                            g = gt(S_IDC, 6'd12);
                        end
                        S_IDC:
                        begin
                            b = emp(b, av1sh_pkg::E_IDC, v, cur.pc);
                            g = gt(S_LEVEL, 6'd5);
                        end
                        S_LEVEL:
                        begin
                            b = emp(b, av1sh_pkg::E_LEVEL, v, cur.pc);
                            if (cur.pc == sel_reg)
                                st_next.lvl = v[4:0];
                            if (v > 32'd7)
                                g = gt(S_TIER, 6'd1);
                            else
                            begin
                                b = emp(b, av1sh_pkg::E_TIER, '0, cur.pc);
                                if (cur.pc == sel_reg)
                                    st_next.tier = 1'b0;
                                do_at = 1'b1;
                            end
                        end
                        S_TIER:
                        begin
                            b = emp(b, av1sh_pkg::E_TIER, v, cur.pc);
                            if (cur.pc == sel_reg)
                                st_next.tier = v[0];
                            do_at = 1'b1;
                        end
                        S_MODEL_OP:
                        begin
                            b = emp(b, av1sh_pkg::E_MODEL_OP, v, cur.pc);
                            if (vb)
                                g = gt(S_DEC_DELAY, cur.dlen);
                            else
                                do_am = 1'b1;
                        end
                        S_DEC_DELAY:
                        begin
                            b = emp(b, av1sh_pkg::E_DEC_DELAY, v, cur.pc);
                            g = gt(S_ENC_DELAY, cur.dlen);
                        end
                        S_ENC_DELAY:
                        begin
                            b = emp(b, av1sh_pkg::E_ENC_DELAY, v, cur.pc);
                            g = gt(S_LOW_DELAY, 6'd1);
                        end
                        S_LOW_DELAY:
                        begin
                            b = emp(b, av1sh_pkg::E_LOW_DELAY, v, cur.pc);
                            do_am = 1'b1;
                        end
                        S_IDD_OP:
                        begin
                            b = emp(b, av1sh_pkg::E_IDD_OP, v, cur.pc);
                            if (vb)
                                g = gt(S_IDD_M1, 6'd4);
                            else
                                do_pd = 1'b1;
                        end
                        S_IDD_M1:
                        begin
                            b = emp(b, av1sh_pkg::E_IDD_M1, v, cur.pc);
                            do_pd = 1'b1;
                        end
                        S_FWB:
                        begin
                            st_next.wbits = {1'b0, v[3:0]} + 5'd1;
                            b = em(b, av1sh_pkg::E_FWB, 32'(st_next.wbits));
                            g = gt(S_FHB, 6'd4);
                        end
                        S_FHB:
                        begin
                            st_next.hbits = {1'b0, v[3:0]} + 5'd1;
                            b = em(b, av1sh_pkg::E_FHB, 32'(st_next.hbits));
                            g = gt(S_MAXW, 6'(cur.wbits));
                        end
                        S_MAXW:
                        begin
                            b = em(b, av1sh_pkg::E_MAXW, v + 32'd1);
                            g = gt(S_MAXH, 6'(cur.hbits));
                        end
                        S_MAXH:
                        begin
                            b = em(b, av1sh_pkg::E_MAXH, v + 32'd1);
                            g = cur.reduced ? gt(S_SB128, 6'd1) : gt(S_FID, 6'd1);
                        end
                        S_FID:
                        begin
                            b = em(b, av1sh_pkg::E_FID, v);
                            g = vb ? gt(S_DELTA_ID, 6'd4) : gt(S_SB128, 6'd1);
                        end
                        S_DELTA_ID:
                        begin
                            b = em(b, av1sh_pkg::E_DELTA_ID, v + 32'd2);
                            g = gt(S_ADD_ID, 6'd3);
                        end
                        S_ADD_ID:
                        begin
                            b = em(b, av1sh_pkg::E_ADD_ID, v + 32'd1);
                            g = gt(S_SB128, 6'd1);
                        end
                        S_SB128:
                        begin
                            b = em(b, av1sh_pkg::E_SB128, v);
                            g = gt(S_FINTRA, 6'd1);
                        end
                        S_FINTRA:
                        begin
                            b = em(b, av1sh_pkg::E_FINTRA, v);
                            g = gt(S_EDGE, 6'd1);
                        end
                        S_EDGE:
                        begin
                            b = em(b, av1sh_pkg::E_EDGE, v);
                            if (cur.reduced)
                            begin
                                b = em(b, av1sh_pkg::E_SCT, 32'd2);
                                b = em(b, av1sh_pkg::E_IMV, 32'd2);
                                g = gt(S_SUPERRES, 6'd1);
                            end
                            else
                                g = gt(S_INTERINTRA, 6'd1);
                        end
                        S_INTERINTRA:
                        begin
                            b = em(b, av1sh_pkg::E_INTERINTRA, v);
                            g = gt(S_MASKED, 6'd1);
                        end
                        S_MASKED:
                        begin
                            b = em(b, av1sh_pkg::E_MASKED, v);
                            g = gt(S_WARPED, 6'd1);
                        end
                        S_WARPED:
                        begin
                            b = em(b, av1sh_pkg::E_WARPED, v);
                            g = gt(S_DUAL, 6'd1);
                        end
                        S_DUAL:
                        begin
                            b = em(b, av1sh_pkg::E_DUAL, v);
                            g = gt(S_ORDER, 6'd1);
                        end
                        S_ORDER:
                        begin
                            st_next.order = vb;
                            b = em(b, av1sh_pkg::E_ORDER, v);
                            g = vb ? gt(S_JNT, 6'd1) : gt(S_SCT_CHOOSE, 6'd1);
                        end
                        S_JNT:
                        begin
                            b = em(b, av1sh_pkg::E_JNT, v);
                            g = gt(S_REFMVS, 6'd1);
                        end
                        S_REFMVS:
                        begin
                            b = em(b, av1sh_pkg::E_REFMVS, v);
                            g = gt(S_SCT_CHOOSE, 6'd1);
                        end
                        S_SCT_CHOOSE:
                        begin
                            if (vb)
                            begin
                                b = em(b, av1sh_pkg::E_SCT, 32'd2);
                                g = gt(S_IMV_CHOOSE, 6'd1);
                            end
                            else
                                g = gt(S_SCT, 6'd1);
                        end
                        S_SCT:
                        begin
                            b = em(b, av1sh_pkg::E_SCT, v);
                            if (vb)
                                g = gt(S_IMV_CHOOSE, 6'd1);
                            else
                            begin
                                b = em(b, av1sh_pkg::E_IMV, 32'd2);
                                do_ai = 1'b1;
                            end
                        end
                        S_IMV_CHOOSE:
                        begin
                            if (vb)
                            begin
                                b = em(b, av1sh_pkg::E_IMV, 32'd2);
                                do_ai = 1'b1;
                            end
                            else
                                g = gt(S_IMV, 6'd1);
                        end
                        S_IMV:
                        begin
                            b = em(b, av1sh_pkg::E_IMV, v);
                            do_ai = 1'b1;
                        end
                        S_OHB:
                        begin
                            b = em(b, av1sh_pkg::E_OHB, v + 32'd1);
                            g = gt(S_SUPERRES, 6'd1);
                        end
                        S_SUPERRES:
                        begin
                            b = em(b, av1sh_pkg::E_SUPERRES, v);
                            g = gt(S_CDEF, 6'd1);
                        end
                        S_CDEF:
                        begin
                            b = em(b, av1sh_pkg::E_CDEF, v);
                            g = gt(S_RESTORE, 6'd1);
                        end
                        S_RESTORE:
                        begin
                            b = em(b, av1sh_pkg::E_RESTORE, v);
                            g = gt(S_HIGH_BD, 6'd1);
                        end
                        S_HIGH_BD:
                        begin
                            if (cur.prof == 3'd2 && vb)
                                g = gt(S_TWELVE, 6'd1);
                            else
                            begin
                                st_next.depth = vb ? 2'd1 : 2'd0;
                                b = em(b, av1sh_pkg::E_BIT_DEPTH, vb ? 32'd10 : 32'd8);
                                do_ad = 1'b1;
                            end
                        end
                        S_TWELVE:
                        begin
                            st_next.depth = vb ? 2'd2 : 2'd1;
                            b = em(b, av1sh_pkg::E_BIT_DEPTH, vb ? 32'd12 : 32'd10);
                            do_ad = 1'b1;
                        end
                        S_MONO:
                        begin
                            st_next.mono = vb;
                            b = em(b, av1sh_pkg::E_MONO, v);
                            g = gt(S_DESC, 6'd1);
                        end
                        S_DESC:
                        begin
                            if (vb)
                                g = gt(S_PRIM, 6'd8);
                            else
                            begin
                                st_next.colour = 24'h020202;
                                b = em(b, av1sh_pkg::E_PRIM, 32'd2);
                                b = em(b, av1sh_pkg::E_TRANSFER, 32'd2);
                                b = em(b, av1sh_pkg::E_MATRIX, 32'd2);
                                do_desc = 1'b1;
                            end
                        end
                        S_PRIM:
                        begin
                            st_next.colour = {v[7:0], 16'h0000};
                            b = em(b, av1sh_pkg::E_PRIM, v);
                            g = gt(S_TRANSFER, 6'd8);
                        end
                        S_TRANSFER:
                        begin
                            st_next.colour[15:8] = v[7:0];
                            b = em(b, av1sh_pkg::E_TRANSFER, v);
                            g = gt(S_MATRIX, 6'd8);
                        end
                        S_MATRIX:
                        begin
                            st_next.colour[7:0] = v[7:0];
                            b = em(b, av1sh_pkg::E_MATRIX, v);
                            do_desc = 1'b1;
                        end
                        S_RANGE:
                        begin
                            b = em(b, av1sh_pkg::E_RANGE, v);
                            if (cur.mono)
                            begin
                                b = em(b, av1sh_pkg::E_SSX, 32'd1);
                                b = em(b, av1sh_pkg::E_SSY, 32'd1);
                                b = em(b, av1sh_pkg::E_CSP, '0);
                                b = em(b, av1sh_pkg::E_SEP_UV, '0);
                                g = gt(S_FILM, 6'd1);
                            end
                            else if (cur.prof == 3'd0)
                            begin
                                b = em(b, av1sh_pkg::E_SSX, 32'd1);
                                b = em(b, av1sh_pkg::E_SSY, 32'd1);
                                g = gt(S_CSP, 6'd2);
                            end
                            else if (cur.prof == 3'd1)
                            begin
                                b = em(b, av1sh_pkg::E_SSX, '0);
                                b = em(b, av1sh_pkg::E_SSY, '0);
                                b = em(b, av1sh_pkg::E_CSP, '0);
                                g = gt(S_SEP_UV, 6'd1);
                            end
                            else if (cur.depth == 2'd2)
                                g = gt(S_SSX, 6'd1);
                            else
                            begin
                                b = em(b, av1sh_pkg::E_SSX, 32'd1);
                                b = em(b, av1sh_pkg::E_SSY, '0);
                                b = em(b, av1sh_pkg::E_CSP, '0);
                                g = gt(S_SEP_UV, 6'd1);
                            end
                        end
                        S_SSX:
                        begin
                            b = em(b, av1sh_pkg::E_SSX, v);
                            if (vb)
                                g = gt(S_SSY, 6'd1);
                            else
                            begin
                                b = em(b, av1sh_pkg::E_SSY, '0);
                                b = em(b, av1sh_pkg::E_CSP, '0);
                                g = gt(S_SEP_UV, 6'd1);
                            end
                        end
                        S_SSY:
                        begin
                            b = em(b, av1sh_pkg::E_SSY, v);
                            if (vb)
                                g = gt(S_CSP, 6'd2);
                            else
                            begin
                                b = em(b, av1sh_pkg::E_CSP, '0);
                                g = gt(S_SEP_UV, 6'd1);
                            end
                        end
                        S_CSP:
                        begin
                            b = em(b, av1sh_pkg::E_CSP, v);
                            g = gt(S_SEP_UV, 6'd1);
                        end
                        S_SEP_UV:
                        begin
                            b = em(b, av1sh_pkg::E_SEP_UV, v);
                            g = gt(S_FILM, 6'd1);
                        end
                        S_FILM:
                        begin
                            b = em(b, av1sh_pkg::E_FILM, v);
                            g = gt(S_TRAIL_ONE, '0);
                        end
                        default:
                            g = gt(S_IDLE, '0);
                    endcase
                end
            end
        end
        // follow-on decisions shared by several syntax steps
        if (do_at)
        begin
            if (cur.dmi)
                g = gt(S_MODEL_OP, 6'd1);
            else
                do_am = 1'b1;
        end
        if (do_am)
        begin
            if (cur.idd)
                g = gt(S_IDD_OP, 6'd1);
            else
                do_pd = 1'b1;
        end
        if (do_pd)
        begin
            if (cur.pc == cur.pm1)
            begin
                if (sel_reg > cur.pm1
                    || {1'b0, sel_reg} >= (av1sh_pkg::PT_W + 1)'(av1sh_pkg::MAX_POINTS))
                begin
                    b = fin(b, av1sh_pkg::ST_BAD_ARG);
                    g = gt(S_IDLE, '0);
                end
                else
                begin
                    b = emp(b, av1sh_pkg::E_SEL_LEVEL, 32'(st_next.lvl), sel_reg);
                    b = emp(b, av1sh_pkg::E_SEL_TIER, 32'(st_next.tier), sel_reg);
                    g = gt(S_FWB, 6'd4);
                end
            end
            else
            begin
                st_next.pc = cur.pc + av1sh_pkg::PT_W'(1);
                g = gt(S_IDC, 6'd12);
            end
        end
        if (do_ai)
            g = cur.order ? gt(S_OHB, 6'd3) : gt(S_SUPERRES, 6'd1);
        if (do_ad)
        begin
            if (cur.prof == 3'd1)
            begin
                st_next.mono = 1'b0;
                b = em(b, av1sh_pkg::E_MONO, '0);
                g = gt(S_DESC, 6'd1);
            end
            else
                g = gt(S_MONO, 6'd1);
        end
        if (do_desc)
        begin
            if (!st_next.mono && st_next.colour == 24'h010D00)
            begin
                b = em(b, av1sh_pkg::E_RANGE, 32'd1);
                b = em(b, av1sh_pkg::E_SSX, '0);
                b = em(b, av1sh_pkg::E_SSY, '0);
                g = gt(S_SEP_UV, 6'd1);
            end
            else
                g = gt(S_RANGE, 6'd1);
        end
        if (g.en)
        begin
            st_next.step = g.step;
            st_next.left = g.len;
            st_next.acc = '0;
        end
    end

    assign batch = b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
            sel_reg <= '0;
        end
        else
        begin
            sel_reg <= sel_next;
            if (accept)
                st_reg <= st_next;
        end
    end

endmodule

[hw/rtl/av1sh_outq.sv]
// result register: holds a bit's batch, hands out a word per out_ready cycle
// depends on av1sh_pkg
module av1sh_outq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  av1sh_pkg::batch_t batch_in,
    output logic              can_load,
    output logic              out_valid,
    input  logic              out_ready,
    output av1sh_pkg::out_t   out_word
);

    av1sh_pkg::res_t [av1sh_pkg::MAX_RES-1:0] slot_reg;
    logic [av1sh_pkg::CNT_W-1:0] cnt_reg, cnt_next, idx_reg, idx_next;
    logic busy, last;
    av1sh_pkg::res_t cur;

    assign busy = idx_reg < cnt_reg;
    assign last = (idx_reg + av1sh_pkg::CNT_W'(1)) == cnt_reg;
    assign can_load = !busy || (last && out_ready);
    assign out_valid = busy;
    assign cur = slot_reg[idx_reg];

    always_comb
    begin
        out_word.element_code = cur.code;
        out_word.element_value = cur.value;
        out_word.point_index = cur.point;
        out_word.parse_status = cur.status;
        out_word.run_last = last;
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (load)
        begin
            cnt_next = batch_in.cnt;
            idx_next = '0;
        end
        else if (busy && out_ready)
            idx_next = idx_reg + av1sh_pkg::CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            slot_reg <= batch_in.slot;
    end

endmodule

[hw/rtl/av1_sequence_header_parser.sv]
// AV1 sequence header parser: takes one payload bit per accepted word and
// reports each completed syntax element, then a closing status. A bit is
// accepted every cycle while it yields at most one result and out_ready is
// high; a bit with more results holds the input until its last word is out,
// as results leave one word per ready cycle. Configuration is always ready.
// depends on av1sh_pkg, av1sh_step, av1sh_outq and the macros header
`include "av1_sequence_header_parser_macros.svh"
module av1_sequence_header_parser (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  av1sh_pkg::in_t             in_word,
    output logic                       out_valid,
    input  logic                       out_ready,
    output av1sh_pkg::out_t            out_word,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [av1sh_pkg::PT_W-1:0] cfg_data
);

    logic in_accept;
    av1sh_pkg::batch_t batch;

    assign cfg_ready = 1'b1;
    assign in_accept = in_valid && in_ready;

    av1sh_step u_step (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (in_accept),
        .word     (in_word),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .batch    (batch)
    );

    av1sh_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_accept),
        .batch_in  (batch),
        .can_load  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    `AV1SH_ASSERT_SAME(a_load_only_on_last, in_ready && out_valid, out_ready && out_word.run_last)
    `AV1SH_ASSERT_NEXT(a_batch_continues, out_valid && out_ready && !out_word.run_last, out_valid)
    `AV1SH_ASSERT_SAME(a_status_is_last, out_valid && out_word.parse_status != 2'(av1sh_pkg::ST_ELEM), out_word.run_last)

endmodule

[tb/testbench.sv]
// self-checking testbench for av1_sequence_header_parser: random and directed header bits,
// an internal model of the sequence header syntax predicts every result word
// depends on av1sh_pkg and the parser rtl
`timescale 1ns / 100ps
module testbench;

    localparam int LIMIT = 400000;

    typedef enum int {
        PS_IDLE, PS_PROFILE, PS_STILL, PS_REDUCED, PS_RLEVEL, PS_TIMING, PS_DISP_TICK,
        PS_TIME_SCALE, PS_EQUAL, PS_UVLC, PS_UVLC_BITS, PS_DMI, PS_BDL, PS_DEC_TICK,
        PS_BRTL, PS_FPTL, PS_IDD, PS_OPS, PS_IDC, PS_LEVEL, PS_TIER, PS_MODEL_OP,
        PS_DEC_DELAY, PS_ENC_DELAY, PS_LOW_DELAY, PS_IDD_OP, PS_IDD_M1, PS_FWB, PS_FHB,
        PS_MAXW, PS_MAXH, PS_FID, PS_DELTA_ID, PS_ADD_ID, PS_SB128, PS_FINTRA, PS_EDGE,
        PS_INTERINTRA, PS_MASKED, PS_WARPED, PS_DUAL, PS_ORDER, PS_JNT, PS_REFMVS,
        PS_SCT_CHOOSE, PS_SCT, PS_IMV_CHOOSE, PS_IMV, PS_OHB, PS_SUPERRES, PS_CDEF,
        PS_RESTORE, PS_HIGH_BD, PS_TWELVE, PS_MONO, PS_DESC, PS_PRIM, PS_TRANSFER,
        PS_MATRIX, PS_RANGE, PS_SSX, PS_SSY, PS_CSP, PS_SEP_UV, PS_FILM, PS_TRAIL_ONE,
        PS_TRAIL_ZERO
    } syntax_step_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    av1sh_pkg::in_t in_word = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    av1sh_pkg::out_t out_word;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [av1sh_pkg::PT_W-1:0] cfg_data = '0;

    av1_sequence_header_parser dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
        .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    av1sh_pkg::in_t  bit_q[$];
    av1sh_pkg::out_t expected_words[$];
    av1sh_pkg::out_t bit_words[$];
    int errors = 0;
    int bits_sent = 0;
    int words_checked = 0;
    int headers_built = 0;
    int cycles = 0;
    int snd_pct = 0;
    int rcv_pct = 0;
    int cfg_req_cnt = 0;
    int cfg_done_cnt = 0;
    logic [av1sh_pkg::PT_W-1:0] cfg_next = '0;
    logic hold_kick = 1'b0;
    logic hold_kicked = 1'b0;
    int hold_cnt = 0;

    // parser model state
    logic [4:0]   sel_point = '0;
    syntax_step_t ps = PS_IDLE;
    logic [5:0]   bits_left, zeros, dly_len;
    logic [31:0]  acc;
    logic [2:0]   profile, pos8;
    logic [4:0]   last_pt, pt, wbits, hbits, lvl_sel;
    logic [23:0]  colour;
    logic [1:0]   depth;
    logic         tier_sel, f_still, f_reduced, f_dmi, f_idd, f_order, f_mono, f_tick0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    function automatic void add(input av1sh_pkg::elem_t c, input logic [31:0] v,
                                input logic [4:0] p, input av1sh_pkg::status_t s);
        av1sh_pkg::out_t w;
        if (bit_words.size() < av1sh_pkg::MAX_RES)
        begin
            w.element_code = c;
            w.element_value = v;
            w.point_index = p;
            w.parse_status = s;
            w.run_last = 1'b0;
            bit_words.push_back(w);
        end
    endfunction

    function automatic void el(input av1sh_pkg::elem_t c, input logic [31:0] v);
        add(c, v, 5'd0, av1sh_pkg::ST_ELEM);
    endfunction

    function automatic void el_pt(input av1sh_pkg::elem_t c, input logic [31:0] v);
        add(c, v, pt, av1sh_pkg::ST_ELEM);
    endfunction

    function automatic void go(input syntax_step_t s, input logic [5:0] n);
        ps = s;
        bits_left = n;
        acc = '0;
    endfunction

    // status words carry code zero
    function automatic void close_run(input av1sh_pkg::status_t s);
        add(av1sh_pkg::E_PROFILE, 32'd0, 5'd0, s);
        ps = PS_IDLE;
    endfunction

    function automatic void point_done();
        if (pt == last_pt)
        begin
            if (sel_point > last_pt)
                close_run(av1sh_pkg::ST_BAD_ARG);
            else
            begin
                add(av1sh_pkg::E_SEL_LEVEL, 32'(lvl_sel), sel_point, av1sh_pkg::ST_ELEM);
                add(av1sh_pkg::E_SEL_TIER, 32'(tier_sel), sel_point, av1sh_pkg::ST_ELEM);
                go(PS_FWB, 6'd4);
            end
        end
        else
        begin
            pt = pt + 5'd1;
            go(PS_IDC, 6'd12);
        end
    endfunction

    function automatic void after_model();
        if (f_idd) go(PS_IDD_OP, 6'd1); else point_done();
    endfunction

    function automatic void after_tier();
        if (f_dmi) go(PS_MODEL_OP, 6'd1); else after_model();
    endfunction

    function automatic void after_imv();
        if (f_order) go(PS_OHB, 6'd3); else go(PS_SUPERRES, 6'd1);
    endfunction

    function automatic void after_depth();
        if (profile == 3'd1)
        begin
            f_mono = 1'b0;
            el(av1sh_pkg::E_MONO, 32'd0);
            go(PS_DESC, 6'd1);
        end
        else
            go(PS_MONO, 6'd1);
    endfunction

    function automatic void after_desc();
        // srgb primaries with identity matrix
        if (!f_mono && colour == 24'h010D00)
        begin
            el(av1sh_pkg::E_RANGE, 32'd1);
            el(av1sh_pkg::E_SSX, 32'd0);
            el(av1sh_pkg::E_SSY, 32'd0);
            go(PS_SEP_UV, 6'd1);
        end
        else
            go(PS_RANGE, 6'd1);
    endfunction

    function automatic void field_done(input logic [31:0] v);
        case (ps)
            PS_PROFILE:
            begin
                profile = v[2:0];
                el(av1sh_pkg::E_PROFILE, v);
                go(PS_STILL, 6'd1);
            end
            PS_STILL:
            begin
                f_still = v[0];
                el(av1sh_pkg::E_STILL, v);
                go(PS_REDUCED, 6'd1);
            end
            PS_REDUCED:
            begin
                f_reduced = v[0];
                el(av1sh_pkg::E_REDUCED, v);
                if (profile > 3'd2 || (v[0] && !f_still))
                    close_run(av1sh_pkg::ST_BAD_DATA);
                else if (v[0])
                begin
                    if (sel_point != 5'd0)
                        close_run(av1sh_pkg::ST_BAD_ARG);
                    else
                        go(PS_RLEVEL, 6'd5);
                end
                else
                    go(PS_TIMING, 6'd1);
            end
            PS_RLEVEL:
            begin
                pt = '0;
                el_pt(av1sh_pkg::E_LEVEL, v);
                el(av1sh_pkg::E_OPS, 32'd1);
                el(av1sh_pkg::E_SEL_LEVEL, v);
                el(av1sh_pkg::E_SEL_TIER, 32'd0);
                go(PS_FWB, 6'd4);
            end
            PS_TIMING:
            begin
                el(av1sh_pkg::E_TIMING, v);
                if (v[0]) go(PS_DISP_TICK, 6'd32); else go(PS_IDD, 6'd1);
            end
            PS_DISP_TICK:
            begin
                f_tick0 = (v == 0);
                el(av1sh_pkg::E_DISP_TICK, v);
                go(PS_TIME_SCALE, 6'd32);
            end
            PS_TIME_SCALE:
            begin
                el(av1sh_pkg::E_TIME_SCALE, v);
                if (f_tick0 || v == 0)
                    close_run(av1sh_pkg::ST_BAD_DATA);
                else
                    go(PS_EQUAL, 6'd1);
            end
            PS_EQUAL:
            begin
                el(av1sh_pkg::E_EQUAL, v);
                if (v[0])
                begin
                    go(PS_UVLC, 6'd0);
                    zeros = '0;
                end
                else
                    go(PS_DMI, 6'd1);
            end
            PS_UVLC_BITS:
            begin
                el(av1sh_pkg::E_TICKS_M1, v + ((32'd1 << zeros[4:0]) - 32'd1));
                go(PS_DMI, 6'd1);
            end
            PS_DMI:
            begin
                f_dmi = v[0];
                el(av1sh_pkg::E_DMI, v);
                if (v[0]) go(PS_BDL, 6'd5); else go(PS_IDD, 6'd1);
            end
            PS_BDL:
            begin
                dly_len = 6'(v) + 6'd1;
                el(av1sh_pkg::E_BDL, 32'(dly_len));
                go(PS_DEC_TICK, 6'd32);
            end
            PS_DEC_TICK:
            begin
                el(av1sh_pkg::E_DEC_TICK, v);
                if (v == 0)
                    close_run(av1sh_pkg::ST_BAD_DATA);
                else
                    go(PS_BRTL, 6'd5);
            end
            PS_BRTL:
            begin
                el(av1sh_pkg::E_BRTL, v + 32'd1);
                go(PS_FPTL, 6'd5);
            end
            PS_FPTL:
            begin
                el(av1sh_pkg::E_FPTL, v + 32'd1);
                go(PS_IDD, 6'd1);
            end
            PS_IDD:
            begin
                f_idd = v[0];
                el(av1sh_pkg::E_IDD, v);
                go(PS_OPS, 6'd5);
            end
            PS_OPS:
            begin
                last_pt = v[4:0];
                pt = '0;
                el(av1sh_pkg::E_OPS, v + 32'd1);
                go(PS_IDC, 6'd12);
            end
            PS_IDC:
            begin
                el_pt(av1sh_pkg::E_IDC, v);
                go(PS_LEVEL, 6'd5);
            end
            PS_LEVEL:
            begin
                el_pt(av1sh_pkg::E_LEVEL, v);
                if (pt == sel_point) lvl_sel = v[4:0];
                if (v > 7)
                    go(PS_TIER, 6'd1);
                else
                begin
                    el_pt(av1sh_pkg::E_TIER, 32'd0);
                    if (pt == sel_point) tier_sel = 1'b0;
                    after_tier();
                end
            end
            PS_TIER:
            begin
                el_pt(av1sh_pkg::E_TIER, v);
                if (pt == sel_point) tier_sel = v[0];
                after_tier();
            end
            PS_MODEL_OP:
            begin
                el_pt(av1sh_pkg::E_MODEL_OP, v);
                if (v[0]) go(PS_DEC_DELAY, dly_len); else after_model();
            end
            PS_DEC_DELAY:
            begin
                el_pt(av1sh_pkg::E_DEC_DELAY, v);
                go(PS_ENC_DELAY, dly_len);
            end
            PS_ENC_DELAY:
            begin
                el_pt(av1sh_pkg::E_ENC_DELAY, v);
                go(PS_LOW_DELAY, 6'd1);
            end
            PS_LOW_DELAY:
            begin
                el_pt(av1sh_pkg::E_LOW_DELAY, v);
                after_model();
            end
            PS_IDD_OP:
            begin
                el_pt(av1sh_pkg::E_IDD_OP, v);
                if (v[0]) go(PS_IDD_M1, 6'd4); else point_done();
            end
            PS_IDD_M1:
            begin
                el_pt(av1sh_pkg::E_IDD_M1, v);
                point_done();
            end
            PS_FWB:
            begin
                wbits = 5'(v) + 5'd1;
                el(av1sh_pkg::E_FWB, 32'(wbits));
                go(PS_FHB, 6'd4);
            end
            PS_FHB:
            begin
                hbits = 5'(v) + 5'd1;
                el(av1sh_pkg::E_FHB, 32'(hbits));
                go(PS_MAXW, 6'(wbits));
            end
            PS_MAXW:
            begin
                el(av1sh_pkg::E_MAXW, v + 32'd1);
                go(PS_MAXH, 6'(hbits));
            end
            PS_MAXH:
            begin
                el(av1sh_pkg::E_MAXH, v + 32'd1);
                if (f_reduced) go(PS_SB128, 6'd1); else go(PS_FID, 6'd1);
            end
            PS_FID:
            begin
                el(av1sh_pkg::E_FID, v);
                if (v[0]) go(PS_DELTA_ID, 6'd4); else go(PS_SB128, 6'd1);
            end
            PS_DELTA_ID:
            begin
                el(av1sh_pkg::E_DELTA_ID, v + 32'd2);
                go(PS_ADD_ID, 6'd3);
            end
            PS_ADD_ID:
            begin
                el(av1sh_pkg::E_ADD_ID, v + 32'd1);
                go(PS_SB128, 6'd1);
            end
            PS_SB128:
            begin
                el(av1sh_pkg::E_SB128, v);
                go(PS_FINTRA, 6'd1);
            end
            PS_FINTRA:
            begin
                el(av1sh_pkg::E_FINTRA, v);
                go(PS_EDGE, 6'd1);
            end
            PS_EDGE:
            begin
                el(av1sh_pkg::E_EDGE, v);
                if (f_reduced)
                begin
                    el(av1sh_pkg::E_SCT, 32'd2);
                    el(av1sh_pkg::E_IMV, 32'd2);
                    go(PS_SUPERRES, 6'd1);
                end
                else
                    go(PS_INTERINTRA, 6'd1);
            end
            PS_INTERINTRA:
            begin
                el(av1sh_pkg::E_INTERINTRA, v);
                go(PS_MASKED, 6'd1);
            end
            PS_MASKED:
            begin
                el(av1sh_pkg::E_MASKED, v);
                go(PS_WARPED, 6'd1);
            end
            PS_WARPED:
            begin
                el(av1sh_pkg::E_WARPED, v);
                go(PS_DUAL, 6'd1);
            end
            PS_DUAL:
            begin
                el(av1sh_pkg::E_DUAL, v);
                go(PS_ORDER, 6'd1);
            end
            PS_ORDER:
            begin
                f_order = v[0];
                el(av1sh_pkg::E_ORDER, v);
                if (v[0]) go(PS_JNT, 6'd1); else go(PS_SCT_CHOOSE, 6'd1);
            end
            PS_JNT:
            begin
                el(av1sh_pkg::E_JNT, v);
                go(PS_REFMVS, 6'd1);
            end
            PS_REFMVS:
            begin
                el(av1sh_pkg::E_REFMVS, v);
                go(PS_SCT_CHOOSE, 6'd1);
            end
            PS_SCT_CHOOSE:
            begin
                if (v[0])
                begin
                    el(av1sh_pkg::E_SCT, 32'd2);
                    go(PS_IMV_CHOOSE, 6'd1);
                end
                else
                    go(PS_SCT, 6'd1);
            end
            PS_SCT:
            begin
                el(av1sh_pkg::E_SCT, v);
                if (v[0])
                    go(PS_IMV_CHOOSE, 6'd1);
                else
                begin
                    el(av1sh_pkg::E_IMV, 32'd2);
                    after_imv();
                end
            end
            PS_IMV_CHOOSE:
            begin
                if (v[0])
                begin
                    el(av1sh_pkg::E_IMV, 32'd2);
                    after_imv();
                end
                else
                    go(PS_IMV, 6'd1);
            end
            PS_IMV:
            begin
                el(av1sh_pkg::E_IMV, v);
                after_imv();
            end
            PS_OHB:
            begin
                el(av1sh_pkg::E_OHB, v + 32'd1);
                go(PS_SUPERRES, 6'd1);
            end
            PS_SUPERRES:
            begin
                el(av1sh_pkg::E_SUPERRES, v);
                go(PS_CDEF, 6'd1);
            end
            PS_CDEF:
            begin
                el(av1sh_pkg::E_CDEF, v);
                go(PS_RESTORE, 6'd1);
            end
            PS_RESTORE:
            begin
                el(av1sh_pkg::E_RESTORE, v);
                go(PS_HIGH_BD, 6'd1);
            end
            PS_HIGH_BD:
            begin
                if (profile == 3'd2 && v[0])
                    go(PS_TWELVE, 6'd1);
                else
                begin
                    depth = v[0] ? 2'd1 : 2'd0;
                    el(av1sh_pkg::E_BIT_DEPTH, v[0] ? 32'd10 : 32'd8);
                    after_depth();
                end
            end
            PS_TWELVE:
            begin
                depth = v[0] ? 2'd2 : 2'd1;
                el(av1sh_pkg::E_BIT_DEPTH, v[0] ? 32'd12 : 32'd10);
                after_depth();
            end
            PS_MONO:
            begin
                f_mono = v[0];
                el(av1sh_pkg::E_MONO, v);
                go(PS_DESC, 6'd1);
            end
            PS_DESC:
            begin
                if (v[0])
                    go(PS_PRIM, 6'd8);
                else
                begin
                    colour = 24'h020202;
                    el(av1sh_pkg::E_PRIM, 32'd2);
                    el(av1sh_pkg::E_TRANSFER, 32'd2);
                    el(av1sh_pkg::E_MATRIX, 32'd2);
                    after_desc();
                end
            end
            PS_PRIM:
            begin
                colour = {v[7:0], 16'h0};
                el(av1sh_pkg::E_PRIM, v);
                go(PS_TRANSFER, 6'd8);
            end
            PS_TRANSFER:
            begin
                colour[15:8] = v[7:0];
                el(av1sh_pkg::E_TRANSFER, v);
                go(PS_MATRIX, 6'd8);
            end
            PS_MATRIX:
            begin
                colour[7:0] = v[7:0];
                el(av1sh_pkg::E_MATRIX, v);
                after_desc();
            end
            PS_RANGE:
            begin
                el(av1sh_pkg::E_RANGE, v);
                if (f_mono)
                begin
                    el(av1sh_pkg::E_SSX, 32'd1);
                    el(av1sh_pkg::E_SSY, 32'd1);
                    el(av1sh_pkg::E_CSP, 32'd0);
                    el(av1sh_pkg::E_SEP_UV, 32'd0);
                    go(PS_FILM, 6'd1);
                end
                else if (profile == 3'd0)
                begin
                    el(av1sh_pkg::E_SSX, 32'd1);
                    el(av1sh_pkg::E_SSY, 32'd1);
                    go(PS_CSP, 6'd2);
                end
                else if (profile == 3'd1)
                begin
                    el(av1sh_pkg::E_SSX, 32'd0);
                    el(av1sh_pkg::E_SSY, 32'd0);
                    el(av1sh_pkg::E_CSP, 32'd0);
                    go(PS_SEP_UV, 6'd1);
                end
                else if (depth == 2'd2)
                    go(PS_SSX, 6'd1);
                else
                begin
                    el(av1sh_pkg::E_SSX, 32'd1);
                    el(av1sh_pkg::E_SSY, 32'd0);
                    el(av1sh_pkg::E_CSP, 32'd0);
                    go(PS_SEP_UV, 6'd1);
                end
            end
            PS_SSX:
            begin
                el(av1sh_pkg::E_SSX, v);
                if (v[0])
                    go(PS_SSY, 6'd1);
                else
                begin
                    el(av1sh_pkg::E_SSY, 32'd0);
                    el(av1sh_pkg::E_CSP, 32'd0);
                    go(PS_SEP_UV, 6'd1);
                end
            end
            PS_SSY:
            begin
                el(av1sh_pkg::E_SSY, v);
                if (v[0])
                    go(PS_CSP, 6'd2);
                else
                begin
                    el(av1sh_pkg::E_CSP, 32'd0);
                    go(PS_SEP_UV, 6'd1);
                end
            end
            PS_CSP:
            begin
                el(av1sh_pkg::E_CSP, v);
                go(PS_SEP_UV, 6'd1);
            end
            PS_SEP_UV:
            begin
                el(av1sh_pkg::E_SEP_UV, v);
                go(PS_FILM, 6'd1);
            end
            PS_FILM:
            begin
                el(av1sh_pkg::E_FILM, v);
                go(PS_TRAIL_ONE, 6'd0);
            end
            default: ps = PS_IDLE;
        endcase
    endfunction

    function automatic void predict_bit(input av1sh_pkg::in_t w);
        av1sh_pkg::out_t t;
        bit_words.delete();
        if (w.starts_header)
        begin
            zeros = '0; profile = '0; dly_len = '0; last_pt = '0; pt = '0;
            wbits = '0; hbits = '0; colour = '0; depth = '0; pos8 = '0;
            lvl_sel = '0; tier_sel = 1'b0;
            f_still = 1'b0; f_reduced = 1'b0; f_dmi = 1'b0; f_idd = 1'b0;
            f_order = 1'b0; f_mono = 1'b0; f_tick0 = 1'b0;
            go(PS_PROFILE, 6'd3);
        end
        if (ps != PS_IDLE)
        begin
            pos8 = pos8 + 3'd1;
            if (ps == PS_UVLC)
            begin
                if (!w.header_bit)
                begin
                    if (zeros < 6'd32) zeros = zeros + 6'd1;
                end
                else if (zeros >= 6'd32)
                begin
                    el(av1sh_pkg::E_TICKS_M1, 32'hFFFF_FFFF);
                    go(PS_DMI, 6'd1);
                end
                else if (zeros == 6'd0)
                begin
                    el(av1sh_pkg::E_TICKS_M1, 32'd0);
                    go(PS_DMI, 6'd1);
                end
                else
                    go(PS_UVLC_BITS, zeros);
            end
            else if (ps == PS_TRAIL_ONE)
            begin
                if (!w.header_bit) close_run(av1sh_pkg::ST_BAD_DATA);
                else if (pos8 == 3'd0) close_run(av1sh_pkg::ST_DONE);
                else go(PS_TRAIL_ZERO, 6'd0);
            end
            else if (ps == PS_TRAIL_ZERO)
            begin
                if (w.header_bit) close_run(av1sh_pkg::ST_BAD_DATA);
                else if (pos8 == 3'd0) close_run(av1sh_pkg::ST_DONE);
            end
            else
            begin
                acc = {acc[30:0], w.header_bit};
                if (bits_left > 6'd0) bits_left = bits_left - 6'd1;
                if (bits_left == 6'd0) field_done(acc);
            end
        end
        for (int i = 0; i < bit_words.size(); i++)
        begin
            t = bit_words[i];
            t.run_last = (i == bit_words.size() - 1);
            expected_words.push_back(t);
        end
    endfunction

    // bit driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_word <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_bit(in_word);
                bits_sent++;
            end
            if (in_valid && !in_ready)
                ;
            else if (bit_q.size() != 0 && $urandom_range(99) >= snd_pct)
            begin
                in_valid <= 1'b1;
                in_word <= bit_q.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        av1sh_pkg::out_t e;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                words_checked++;
                if (expected_words.size() == 0)
                    report("unexpected word", 32'(out_word.element_code), 32'd0);
                else
                begin
                    e = expected_words.pop_front();
                    if (out_word.element_code !== e.element_code)
                        report("element_code", 32'(out_word.element_code), 32'(e.element_code));
                    if (out_word.element_value !== e.element_value)
                        report("element_value", out_word.element_value, e.element_value);
                    if (out_word.point_index !== e.point_index)
                        report("point_index", 32'(out_word.point_index), 32'(e.point_index));
                    if (out_word.parse_status !== e.parse_status)
                        report("parse_status", 32'(out_word.parse_status), 32'(e.parse_status));
                    if (out_word.run_last !== e.run_last)
                        report("run_last", 32'(out_word.run_last), 32'(e.run_last));
                end
            end
            out_ready <= (hold_cnt == 0) && ($urandom_range(99) >= rcv_pct);
        end
    end

    // long receiver hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_cnt <= 0;
            hold_kicked <= 1'b0;
        end
        else if (hold_kick && !hold_kicked)
        begin
            hold_cnt <= 300;
            hold_kicked <= 1'b1;
        end
        else if (hold_cnt != 0)
            hold_cnt <= hold_cnt - 1;
    end

    // selected point register writes
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_valid <= 1'b0;
            cfg_data <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            cfg_valid <= 1'b0;
            sel_point <= cfg_data;
            cfg_done_cnt <= cfg_done_cnt + 1;
        end
        else if (!cfg_valid && cfg_req_cnt != cfg_done_cnt)
        begin
            cfg_valid <= 1'b1;
            cfg_data <= cfg_next;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    function automatic void put_bit(input logic b, input logic s);
        av1sh_pkg::in_t w;
        w.header_bit = b;
        w.starts_header = s;
        bit_q.push_back(w);
    endfunction

    function automatic void put_bits(input logic [31:0] v, input int n);
        for (int i = n - 1; i >= 0; i--)
            put_bit(v[i], 1'b0);
    endfunction

    function automatic logic rb();
        return logic'($urandom_range(1));
    endfunction

    // one mostly well-formed header with random content
    task automatic gen_header(input int sel);
        int prof, z, dl, ops, lvl, wb, hb, s0;
        logic reduced, still, timing, dmi, idd, m, c, sct, ord, hbd, twelve, mono, srgb;
        s0 = bit_q.size();
        headers_built++;
        prof = ($urandom_range(9) == 0) ? $urandom_range(7, 3) : $urandom_range(2);
        put_bit(prof[2], 1'b1);
        put_bits(prof, 2);
        reduced = ($urandom_range(3) == 0);
        still = reduced ? ($urandom_range(7) != 0) : rb();
        put_bit(still, 1'b0);
        put_bit(reduced, 1'b0);
        dmi = 1'b0;
        idd = 1'b0;
        if (reduced)
            put_bits($urandom, 5);
        else
        begin
            timing = ($urandom_range(3) == 0);
            put_bit(timing, 1'b0);
            if (timing)
            begin
                put_bits(($urandom_range(9) == 0) ? 32'd0 : $urandom, 32);
                put_bits(($urandom_range(9) == 0) ? 32'd0 : $urandom, 32);
                m = rb();
                put_bit(m, 1'b0);
                if (m)
                begin
                    z = ($urandom_range(7) == 0) ? $urandom_range(34, 30) : $urandom_range(5);
                    repeat (z) put_bit(1'b0, 1'b0);
                    put_bit(1'b1, 1'b0);
                    if (z < 32) put_bits($urandom, z);
                end
                dmi = rb();
                put_bit(dmi, 1'b0);
                if (dmi)
                begin
                    dl = $urandom_range(31);
                    put_bits(dl, 5);
                    put_bits(($urandom_range(9) == 0) ? 32'd0 : $urandom, 32);
                    put_bits($urandom, 10);
                end
            end
            idd = rb();
            put_bit(idd, 1'b0);
            case ($urandom_range(9))
                0: ops = $urandom_range(31);
                1: ops = $urandom_range(2);
                default: ops = (sel + $urandom_range(1) > 31) ? 31 : sel + $urandom_range(1);
            endcase
            put_bits(ops, 5);
            for (int p = 0; p <= ops; p++)
            begin
                put_bits($urandom, 12);
                lvl = $urandom_range(31);
                put_bits(lvl, 5);
                if (lvl > 7) put_bit(rb(), 1'b0);
                if (dmi)
                begin
                    m = rb();
                    put_bit(m, 1'b0);
                    if (m)
                    begin
                        put_bits($urandom, dl + 1);
                        put_bits($urandom, dl + 1);
                        put_bit(rb(), 1'b0);
                    end
                end
                if (idd)
                begin
                    m = rb();
                    put_bit(m, 1'b0);
                    if (m) put_bits($urandom, 4);
                end
            end
        end
        wb = $urandom_range(15);
        hb = $urandom_range(15);
        put_bits(wb, 4);
        put_bits(hb, 4);
        put_bits($urandom, wb + 1);
        put_bits($urandom, hb + 1);
        if (!reduced)
        begin
            m = rb();
            put_bit(m, 1'b0);
            if (m) put_bits($urandom, 7);
        end
        put_bits($urandom, 3);
        if (!reduced)
        begin
            put_bits($urandom, 4);
            ord = rb();
            put_bit(ord, 1'b0);
            if (ord) put_bits($urandom, 2);
            c = rb();
            put_bit(c, 1'b0);
            sct = 1'b0;
            if (!c)
            begin
                sct = rb();
                put_bit(sct, 1'b0);
            end
            if (c || sct)
            begin
                m = rb();
                put_bit(m, 1'b0);
                if (!m) put_bit(rb(), 1'b0);
            end
            if (ord) put_bits($urandom, 3);
        end
        put_bits($urandom, 3);
        hbd = rb();
        put_bit(hbd, 1'b0);
        twelve = 1'b0;
        if (prof == 2 && hbd)
        begin
            twelve = rb();
            put_bit(twelve, 1'b0);
        end
        mono = 1'b0;
        if (prof != 1)
        begin
            mono = ($urandom_range(3) == 0);
            put_bit(mono, 1'b0);
        end
        m = rb();
        put_bit(m, 1'b0);
        srgb = 1'b0;
        if (m)
        begin
            if ($urandom_range(2) == 0)
            begin
                put_bits(24'h010D00, 24);
                srgb = 1'b1;
            end
            else
                put_bits($urandom, 24);
        end
        if (!mono && srgb)
            put_bit(rb(), 1'b0);
        else
        begin
            put_bit(rb(), 1'b0);
            if (!mono)
            begin
                if (prof == 0)
                    put_bits($urandom, 2);
                else if (prof == 2 && twelve)
                begin
                    m = rb();
                    put_bit(m, 1'b0);
                    if (m)
                    begin
                        c = rb();
                        put_bit(c, 1'b0);
                        if (c) put_bits($urandom, 2);
                    end
                end
                put_bit(rb(), 1'b0);
            end
        end
        put_bit(rb(), 1'b0);
        if ($urandom_range(9) == 0)
            put_bits($urandom, $urandom_range(1, 8));
        else
        begin
            put_bit(1'b1, 1'b0);
            while ((bit_q.size() - s0) % 8 != 0)
                put_bit(1'b0, 1'b0);
        end
    endtask

    task automatic drain();
        while (bit_q.size() != 0 || in_valid || expected_words.size() != 0 || hold_cnt != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_sel(input logic [4:0] v);
        @(negedge clk);
        cfg_next = v;
        cfg_req_cnt++;
        while (cfg_done_cnt != cfg_req_cnt)
            @(negedge clk);
    endtask

    task automatic run_phase(input int sel, input int sp, input int rp, input int nbits);
        int s0;
        write_sel(sel[4:0]);
        @(negedge clk);
        snd_pct = sp;
        rcv_pct = rp;
        s0 = bits_sent;
        while (bits_sent - s0 < nbits)
        begin
            if ($urandom_range(7) == 0)
                repeat ($urandom_range(1, 6)) put_bit(rb(), ($urandom_range(3) == 0));
            gen_header(sel);
            while (bit_q.size() != 0)
                @(negedge clk);
        end
        drain();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        // idle bits, bad profile, reduced without still, restart into reduced header
        put_bit(1'b1, 1'b0); put_bit(1'b0, 1'b0);
        put_bit(1'b1, 1'b1); put_bits(5'b11000, 4);
        put_bit(1'b0, 1'b1); put_bits(4'b0001, 4);
        put_bit(1'b0, 1'b1); put_bit(1'b0, 1'b0);
        put_bit(1'b0, 1'b1); put_bits(9'b001111111, 9);
        drain();
        run_phase(0, 0, 0, 60);
        run_phase(3, 51, 0, 40);
        run_phase($urandom_range(6, 2), 0, 51, 40);
        @(negedge clk);
        hold_kick = 1'b1;
        run_phase(1, 21, 21, 80);
        run_phase(0, 0, 0, 20);
        $display("sent %0d header bits in %0d headers, checked %0d result words",
                 bits_sent, headers_built, words_checked);
        $display("selected point 0, 1, 3 and random; idle, stall and long hold-off phases");
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
